FILE: sv/fkc_pkg.sv
// Shared types, constants and table functions of the arm pose kinematics pipeline.
package fkc_pkg;

    localparam int DATA_WIDTH_DEF    = 18;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int LANES             = 6;
    localparam int NUM_OUT           = 12;
    localparam int QW                = 34;
    localparam int PW                = 56;
    localparam int FRAC              = 29;
    localparam int CFG_W             = 16;
    localparam int NUM_CFG           = 6;
    localparam int CFG_AW            = 3;

    // Angles in Q.29 radians
    localparam longint PI_Q         = 64'sd1686629713;
    localparam longint TWO_PI_Q     = 64'sd3373259426;
    localparam longint HALF_PI_Q    = 64'sd843314857;
    localparam longint QUARTER_PI_Q = 64'sd421657428;

    // Lane assignment of the six rotation units
    localparam int LANE_BASE        = 0;
    localparam int LANE_SHOULDER    = 1;
    localparam int LANE_ELBOW       = 2;
    localparam int LANE_WRIST_TWO   = 3;
    localparam int LANE_WRIST_THREE = 4;
    localparam int LANE_SUM         = 5;

    typedef logic signed [QW-1:0]   t_q;
    typedef logic signed [2*QW-1:0] t_qq;
    typedef logic signed [PW-1:0]   t_p;
    typedef logic signed [CFG_W-1:0] t_len;
    typedef t_len [NUM_CFG-1:0]     t_len_vec;

    typedef struct packed {
        t_q   x;
        t_q   y;
        t_q   z;
        logic neg;
    } t_rot;

    typedef t_rot [LANES-1:0] t_rot_vec;

    typedef enum logic [CFG_AW-1:0] {
        CFG_BASE_HEIGHT      = 3'd0,
        CFG_UPPER_ARM_LENGTH = 3'd1,
        CFG_FOREARM_LENGTH   = 3'd2,
        CFG_SHOULDER_OFFSET  = 3'd3,
        CFG_WRIST_OFFSET     = 3'd4,
        CFG_TOOL_OFFSET      = 3'd5
    } t_cfg_idx;

    localparam t_len_vec CFG_RESET = {16'sd1348, 16'sd1551, 16'sd1788,
                                      -16'sd6427, -16'sd6963, 16'sd1461};

    // Unsigned restoring division, used only while building constant tables
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        int          i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-idx) in Q.29, built from the odd power series
    function automatic t_q f_arc(input int idx);
        longint acc;
        longint term;
        int     k;
        int     sh;
        acc = 0;
        if (idx == 0) begin
            acc = QUARTER_PI_Q;
        end else begin
            for (k = 0; k < 32; k++) begin
                sh = idx * (2 * k + 1);
                if (sh < 60) begin
                    term = longint'(f_udiv(64'((64'sd1 <<< 60) >>> sh), 64'(2 * k + 1)));
                    if (k[0]) acc = acc - term;
                    else acc = acc + term;
                end
            end
            acc = (acc + (64'sd1 <<< 30)) >>> 31;
        end
        return t_q'(acc);
    endfunction

    // Start value of x: inverse rotation gain over n stages, Q.29
    function automatic t_q f_x0(input int n);
        longint unsigned k2;
        longint unsigned r;
        longint unsigned b;
        longint unsigned m;
        int              i;
        k2 = 64'd1 << 60;
        for (i = 0; i < 30; i++) begin
            if (i < n) k2 = k2 - f_udiv(k2, (64'd1 << (2 * i)) + 64'd1);
        end
        m = k2;
        r = 0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (b > m) b = b >> 2;
        end
        for (i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (m >= r + b) begin
                    m = m - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return t_q'((r + 64'd1) >> 1);
    endfunction

    // Q.29 product, rounded to nearest (ties up)
    function automatic t_q f_mulq(input t_q a, input t_q b);
        t_qq p;
        p = t_qq'(a) * t_qq'(b);
        p = p + (t_qq'(1) <<< (FRAC - 1));
        return p[QW-1+FRAC:FRAC];
    endfunction

    // Length (Q.14) times trig value (Q.29), exact in Q.43
    function automatic t_p f_lmul(input t_len l, input t_q t);
        return t_p'(l) * t_p'(t);
    endfunction

    function automatic t_q f_sin(input t_rot r);
        return r.neg ? -r.y : r.y;
    endfunction

    function automatic t_q f_cos(input t_rot r);
        return r.neg ? -r.x : r.x;
    endfunction

endpackage

FILE: sv/fkc_reduce_cell.sv
// One cell of the angle reduction row: conditional subtract of 2*pi*2^SHIFT on all lanes.
module fkc_reduce_cell #(
    parameter int MW    = 35,
    parameter int SHIFT = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [fkc_pkg::LANES-1:0][MW-1:0]   i_mag,
    input  logic [fkc_pkg::LANES-1:0]           i_sgn,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [fkc_pkg::LANES-1:0][MW-1:0]   o_mag,
    output logic [fkc_pkg::LANES-1:0]           o_sgn
);
    import fkc_pkg::*;

    localparam logic [MW-1:0] STEP = MW'(TWO_PI_Q) << SHIFT;

    logic                       r_valid;
    logic [LANES-1:0][MW-1:0]   r_mag;
    logic [LANES-1:0]           r_sgn;
    logic [LANES-1:0][MW-1:0]   n_mag;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_sgn   = r_sgn;

    // Restoring step on the magnitude of each lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_mag[l] = (i_mag[l] >= STEP) ? (i_mag[l] - STEP) : i_mag[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag <= n_mag;
            r_sgn <= i_sgn;
        end
    end

endmodule

FILE: sv/fkc_cordic_cell.sv
// One CORDIC rotation step for all six lanes, registered.
module fkc_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fkc_pkg::t_rot_vec  i_rot,
    output logic               o_valid,
    input  logic               i_ready,
    output fkc_pkg::t_rot_vec  o_rot
);
    import fkc_pkg::*;

    localparam t_q ARC = f_arc(IDX);

    logic     r_valid;
    t_rot_vec r_rot;
    t_rot_vec n_rot;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rot   = r_rot;

    // Rotate toward zero residual angle
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_rot[l].neg = i_rot[l].neg;
            if (i_rot[l].z >= 0) begin
                n_rot[l].x = i_rot[l].x - (i_rot[l].y >>> IDX);
                n_rot[l].y = i_rot[l].y + (i_rot[l].x >>> IDX);
                n_rot[l].z = i_rot[l].z - ARC;
            end else begin
                n_rot[l].x = i_rot[l].x + (i_rot[l].y >>> IDX);
                n_rot[l].y = i_rot[l].y - (i_rot[l].x >>> IDX);
                n_rot[l].z = i_rot[l].z + ARC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rot <= n_rot;
        end
    end

endmodule

FILE: sv/fkc_pose.sv
// Pose assembly pipeline: trig products, rotation entries, positions, rounding and saturation.
module fkc_pose #(
    parameter int DW = fkc_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  fkc_pkg::t_rot_vec                 i_rot,
    input  fkc_pkg::t_len_vec                 i_len,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [fkc_pkg::NUM_OUT*DW-1:0]    o_data
);
    import fkc_pkg::*;

    localparam t_p SMAX = t_p'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam t_p SMIN = -t_p'(64'sd1 <<< (DW - 1));

    logic e1, e2, e3, e4, e5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    t_q s1, c1, s2, c2, s3, c3, s5, c5, s6, c6, s234, c234;

    // stage 1
    t_q r1_c1c234, r1_s1c234, r1_c1s, r1_s1s, r1_s1s5, r1_c1s5, r1_c5s1, r1_c1c5;
    t_q r1_s234s5, r1_c234s6, r1_s234c5, r1_c234c6, r1_c2c3, r1_s2s3, r1_s2c3, r1_c2s3;
    t_q r1_c1c2, r1_s1c2, r1_c1, r1_s1, r1_c5, r1_s5, r1_c6, r1_s6, r1_s2, r1_c234;
    // stage 2
    t_q r2_a, r2_b, r2_r0, r2_r3, r2_r6, r2_r7, r2_r8, r2_c23, r2_s23;
    t_q r2_c1s, r2_s1s, r2_c1, r2_s1, r2_c6, r2_s6, r2_c1c2, r2_s1c2, r2_s2, r2_c234;
    // stage 3
    t_q r3_r0, r3_r1, r3_r2, r3_r3, r3_r4, r3_r5, r3_r6, r3_r7, r3_r8;
    t_q r3_c1c23, r3_s1c23;
    t_p r3_pxa, r3_pya, r3_pz;
    // stage 4
    t_q r4_r0, r4_r1, r4_r2, r4_r3, r4_r4, r4_r5, r4_r6, r4_r7, r4_r8;
    t_p r4_px, r4_py, r4_pz;
    // output register
    logic [NUM_OUT*DW-1:0] r_data;
    logic [NUM_OUT*DW-1:0] n_data;

    t_len d1, a2, a3, d4, d5, d6;

    function automatic logic [DW-1:0] f_sat(input t_p v);
        t_p s;
        s = v;
        if (s > SMAX) s = SMAX;
        if (s < SMIN) s = SMIN;
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] f_rot_out(input t_q r);
        t_p v;
        v = (t_p'(r) + (t_p'(1) <<< 14)) >>> 15;
        return f_sat(v);
    endfunction

    function automatic logic [DW-1:0] f_pos_out(input t_p p);
        t_p v;
        v = (p + (t_p'(1) <<< (FRAC - 1))) >>> FRAC;
        return f_sat(v);
    endfunction

    assign d1 = i_len[CFG_BASE_HEIGHT];
    assign a2 = i_len[CFG_UPPER_ARM_LENGTH];
    assign a3 = i_len[CFG_FOREARM_LENGTH];
    assign d4 = i_len[CFG_SHOULDER_OFFSET];
    assign d5 = i_len[CFG_WRIST_OFFSET];
    assign d6 = i_len[CFG_TOOL_OFFSET];

    assign s1   = f_sin(i_rot[LANE_BASE]);
    assign c1   = f_cos(i_rot[LANE_BASE]);
    assign s2   = f_sin(i_rot[LANE_SHOULDER]);
    assign c2   = f_cos(i_rot[LANE_SHOULDER]);
    assign s3   = f_sin(i_rot[LANE_ELBOW]);
    assign c3   = f_cos(i_rot[LANE_ELBOW]);
    assign s5   = f_sin(i_rot[LANE_WRIST_TWO]);
    assign c5   = f_cos(i_rot[LANE_WRIST_TWO]);
    assign s6   = f_sin(i_rot[LANE_WRIST_THREE]);
    assign c6   = f_cos(i_rot[LANE_WRIST_THREE]);
    assign s234 = f_sin(i_rot[LANE_SUM]);
    assign c234 = f_cos(i_rot[LANE_SUM]);

    // Stage enables: a stage loads when empty or when its successor loads
    assign e5      = !r_v5 || i_ready;
    assign e4      = !r_v4 || e5;
    assign e3      = !r_v3 || e4;
    assign e2      = !r_v2 || e3;
    assign e1      = !r_v1 || e2;
    assign o_ready = e1;
    assign o_valid = r_v5;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (e1) r_v1 <= i_valid;
            if (e2) r_v2 <= r_v1;
            if (e3) r_v3 <= r_v2;
            if (e4) r_v4 <= r_v3;
            if (e5) r_v5 <= r_v4;
        end
    end

    // Pairwise trig products
    always_ff @(posedge i_clk) begin
        if (e1 && i_valid) begin
            r1_c1c234 <= f_mulq(c1, c234);
            r1_s1c234 <= f_mulq(s1, c234);
            r1_c1s    <= f_mulq(c1, s234);
            r1_s1s    <= f_mulq(s1, s234);
            r1_s1s5   <= f_mulq(s1, s5);
            r1_c1s5   <= f_mulq(c1, s5);
            r1_c5s1   <= f_mulq(c5, s1);
            r1_c1c5   <= f_mulq(c1, c5);
            r1_s234s5 <= f_mulq(s234, s5);
            r1_c234s6 <= f_mulq(c234, s6);
            r1_s234c5 <= f_mulq(s234, c5);
            r1_c234c6 <= f_mulq(c234, c6);
            r1_c2c3   <= f_mulq(c2, c3);
            r1_s2s3   <= f_mulq(s2, s3);
            r1_s2c3   <= f_mulq(s2, c3);
            r1_c2s3   <= f_mulq(c2, s3);
            r1_c1c2   <= f_mulq(c1, c2);
            r1_s1c2   <= f_mulq(s1, c2);
            r1_c1     <= c1;
            r1_s1     <= s1;
            r1_c5     <= c5;
            r1_s5     <= s5;
            r1_c6     <= c6;
            r1_s6     <= s6;
            r1_s2     <= s2;
            r1_c234   <= c234;
        end
    end

    // Triple products and first rotation entries
    always_ff @(posedge i_clk) begin
        if (e2 && r_v1) begin
            r2_a    <= r1_s1s5 + f_mulq(r1_c1c234, r1_c5);
            r2_b    <= f_mulq(r1_s1c234, r1_c5) - r1_c1s5;
            r2_r0   <= f_mulq(r1_c1c234, r1_s5) - r1_c5s1;
            r2_r3   <= r1_c1c5 + f_mulq(r1_s1c234, r1_s5);
            r2_r6   <= -r1_s234s5;
            r2_r7   <= -r1_c234s6 - f_mulq(r1_s234c5, r1_c6);
            r2_r8   <= f_mulq(r1_s234c5, r1_s6) - r1_c234c6;
            r2_c23  <= r1_c2c3 - r1_s2s3;
            r2_s23  <= r1_s2c3 + r1_c2s3;
            r2_c1s  <= r1_c1s;
            r2_s1s  <= r1_s1s;
            r2_c1   <= r1_c1;
            r2_s1   <= r1_s1;
            r2_c6   <= r1_c6;
            r2_s6   <= r1_s6;
            r2_c1c2 <= r1_c1c2;
            r2_s1c2 <= r1_s1c2;
            r2_s2   <= r1_s2;
            r2_c234 <= r1_c234;
        end
    end

    // Remaining rotation entries and most position terms
    always_ff @(posedge i_clk) begin
        if (e3 && r_v2) begin
            r3_r0    <= r2_r0;
            r3_r1    <= f_mulq(r2_c6, r2_a) - f_mulq(r2_s6, r2_c1s);
            r3_r2    <= -f_mulq(r2_c6, r2_c1s) - f_mulq(r2_s6, r2_a);
            r3_r3    <= r2_r3;
            r3_r4    <= f_mulq(r2_c6, r2_b) - f_mulq(r2_s6, r2_s1s);
            r3_r5    <= -f_mulq(r2_c6, r2_s1s) - f_mulq(r2_s6, r2_b);
            r3_r6    <= r2_r6;
            r3_r7    <= r2_r7;
            r3_r8    <= r2_r8;
            r3_c1c23 <= f_mulq(r2_c1, r2_c23);
            r3_s1c23 <= f_mulq(r2_s1, r2_c23);
            r3_pxa   <= f_lmul(d6, r2_r0) - f_lmul(d5, r2_c1s)
                      - f_lmul(d4, r2_s1) - f_lmul(a2, r2_c1c2);
            r3_pya   <= f_lmul(d6, r2_r3) - f_lmul(d5, r2_s1s)
                      + f_lmul(d4, r2_c1) - f_lmul(a2, r2_s1c2);
            r3_pz    <= (t_p'(d1) <<< FRAC) + f_lmul(d6, r2_r6) + f_lmul(a3, r2_s23)
                      + f_lmul(a2, r2_s2) - f_lmul(d5, r2_c234);
        end
    end

    // Forearm terms of x and y
    always_ff @(posedge i_clk) begin
        if (e4 && r_v3) begin
            r4_r0 <= r3_r0;
            r4_r1 <= r3_r1;
            r4_r2 <= r3_r2;
            r4_r3 <= r3_r3;
            r4_r4 <= r3_r4;
            r4_r5 <= r3_r5;
            r4_r6 <= r3_r6;
            r4_r7 <= r3_r7;
            r4_r8 <= r3_r8;
            r4_px <= r3_pxa - f_lmul(a3, r3_c1c23);
            r4_py <= r3_pya - f_lmul(a3, r3_s1c23);
            r4_pz <= r3_pz;
        end
    end

    // Round, saturate and pack, first field lowest
    always_comb begin
        n_data = {f_pos_out(r4_pz), f_rot_out(r4_r8), f_rot_out(r4_r7), f_rot_out(r4_r6),
                  f_pos_out(r4_py), f_rot_out(r4_r5), f_rot_out(r4_r4), f_rot_out(r4_r3),
                  f_pos_out(r4_px), f_rot_out(r4_r2), f_rot_out(r4_r1), f_rot_out(r4_r0)};
    end

    always_ff @(posedge i_clk) begin
        if (e5 && r_v4) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: sv/arm_end_pose_forward_kinematics.sv
// Top level of the six-axis arm forward kinematics pipeline.
//
//   channel     | direction | payload (lowest bit first)
//   ------------+-----------+----------------------------------------------------------
//   s_axis      | in        | angle_base, angle_shoulder, angle_elbow, angle_wrist_one,
//               |           | angle_wrist_two, angle_wrist_three (DATA_WIDTH each)
//   m_axis      | out       | rot_xx rot_xy rot_xz pos_x rot_yx rot_yy rot_yz pos_y
//               |           | rot_zx rot_zy rot_zz pos_z (DATA_WIDTH each)
//   cfg         | in        | register index, 16-bit link length
//
// One joint vector is taken per cycle unless a stalled output has filled the pipeline.
// The path runs through the input register, R = max(DATA_WIDTH - 15, 1) angle reduction
// cells, the rotation cells and the pose stages. Every stage holds its own valid bit, so a
// stalled output only stops the stages behind it once they are full; bubbles are squeezed
// out. Synchronous reset empties the pipeline and loads the default link lengths.
module arm_end_pose_forward_kinematics #(
    parameter int DATA_WIDTH    = fkc_pkg::DATA_WIDTH_DEF,
    parameter int CORDIC_STAGES = fkc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // angle_base, angle_shoulder, angle_elbow, angle_wrist_one, angle_wrist_two,
    // angle_wrist_three, zero pad
    input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]       i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // rot_xx, rot_xy, rot_xz, pos_x, rot_yx, rot_yy, rot_yz, pos_y,
    // rot_zx, rot_zy, rot_zz, pos_z, zero pad
    output logic [((12*DATA_WIDTH+7)/8)*8-1:0]      o_m_axis_tdata,
    input  logic                                    i_cfg_we,
    input  logic [fkc_pkg::CFG_AW-1:0]              i_cfg_addr,
    input  logic [fkc_pkg::CFG_W-1:0]               i_cfg_data
);
    import fkc_pkg::*;

    localparam int OUT_W = ((12 * DATA_WIDTH + 7) / 8) * 8;
    localparam int RED   = (DATA_WIDTH - 15 > 1) ? DATA_WIDTH - 15 : 1;
    localparam int MW    = DATA_WIDTH + 17;
    localparam int AW    = DATA_WIDTH + 18;
    localparam t_q X0    = f_x0(CORDIC_STAGES);

    typedef logic signed [AW-1:0] t_ang;

    // link length registers
    t_len_vec r_len;

    // input register
    logic                       r_v0;
    logic [LANES-1:0][MW-1:0]   r_mag0;
    logic [LANES-1:0]           r_sgn0;
    logic [LANES-1:0][MW-1:0]   n_mag0;
    logic [LANES-1:0]           n_sgn0;
    t_ang [LANES-1:0]           ang;

    // reduction row
    logic [RED:0]                           red_v;
    logic [RED:0]                           red_rdy;
    logic [RED:0][LANES-1:0][MW-1:0]        red_mag;
    logic [RED:0][LANES-1:0]                red_sgn;

    // rotation row
    t_rot_vec                   rot_seed;
    logic     [CORDIC_STAGES:0] cor_v;
    logic     [CORDIC_STAGES:0] cor_rdy;
    t_rot_vec [CORDIC_STAGES:0] cor_rot;

    logic                          pose_rdy;
    logic [NUM_OUT*DATA_WIDTH-1:0] pose_data;

    // Write link lengths; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_BASE_HEIGHT:      r_len[CFG_BASE_HEIGHT]      <= i_cfg_data;
                CFG_UPPER_ARM_LENGTH: r_len[CFG_UPPER_ARM_LENGTH] <= i_cfg_data;
                CFG_FOREARM_LENGTH:   r_len[CFG_FOREARM_LENGTH]   <= i_cfg_data;
                CFG_SHOULDER_OFFSET:  r_len[CFG_SHOULDER_OFFSET]  <= i_cfg_data;
                CFG_WRIST_OFFSET:     r_len[CFG_WRIST_OFFSET]     <= i_cfg_data;
                CFG_TOOL_OFFSET:      r_len[CFG_TOOL_OFFSET]      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack angles, form the three-joint sum, scale to Q.29, split sign and magnitude
    always_comb begin
        ang[LANE_BASE]        = t_ang'($signed(i_s_axis_tdata[0*DATA_WIDTH +: DATA_WIDTH]));
        ang[LANE_SHOULDER]    = t_ang'($signed(i_s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH]));
        ang[LANE_ELBOW]       = t_ang'($signed(i_s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH]));
        ang[LANE_SUM]         = ang[LANE_SHOULDER] + ang[LANE_ELBOW]
                              + t_ang'($signed(i_s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH]));
        ang[LANE_WRIST_TWO]   = t_ang'($signed(i_s_axis_tdata[4*DATA_WIDTH +: DATA_WIDTH]));
        ang[LANE_WRIST_THREE] = t_ang'($signed(i_s_axis_tdata[5*DATA_WIDTH +: DATA_WIDTH]));
        for (int l = 0; l < LANES; l++) begin
            n_sgn0[l] = ang[l][AW-1];
            n_mag0[l] = n_sgn0[l] ? MW'(-(ang[l] <<< 15)) : MW'(ang[l] <<< 15);
        end
    end

    assign o_s_axis_tready = !r_v0 || red_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_v0 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_mag0 <= n_mag0;
            r_sgn0 <= n_sgn0;
        end
    end

    assign red_v[0]   = r_v0;
    assign red_mag[0] = r_mag0;
    assign red_sgn[0] = r_sgn0;

    // Reduce magnitudes below 2*pi, largest multiple first
    for (genvar k = 0; k < RED; k++) begin : g_red
        fkc_reduce_cell #(
            .MW    (MW),
            .SHIFT (RED - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (red_v[k]),
            .o_ready (red_rdy[k]),
            .i_mag   (red_mag[k]),
            .i_sgn   (red_sgn[k]),
            .o_valid (red_v[k+1]),
            .i_ready (red_rdy[k+1]),
            .o_mag   (red_mag[k+1]),
            .o_sgn   (red_sgn[k+1])
        );
    end

    // Restore sign, wrap into [-pi, pi], fold into [-pi/2, pi/2] and seed the rotation
    always_comb begin
        t_q z;
        for (int l = 0; l < LANES; l++) begin
            z = red_sgn[RED][l] ? -t_q'(red_mag[RED][l]) : t_q'(red_mag[RED][l]);
            if (z > t_q'(PI_Q)) z = z - t_q'(TWO_PI_Q);
            else if (z < -t_q'(PI_Q)) z = z + t_q'(TWO_PI_Q);
            rot_seed[l].neg = 1'b0;
            if (z > t_q'(HALF_PI_Q)) begin
                z = z - t_q'(PI_Q);
                rot_seed[l].neg = 1'b1;
            end else if (z < -t_q'(HALF_PI_Q)) begin
                z = z + t_q'(PI_Q);
                rot_seed[l].neg = 1'b1;
            end
            rot_seed[l].x = X0;
            rot_seed[l].y = '0;
            rot_seed[l].z = z;
        end
    end

    assign cor_rot[0]     = rot_seed;
    assign cor_v[0]       = red_v[RED];
    assign red_rdy[RED]   = cor_rdy[0];

    // One rotation step per cell
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
        fkc_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cor_v[i]),
            .o_ready (cor_rdy[i]),
            .i_rot   (cor_rot[i]),
            .o_valid (cor_v[i+1]),
            .i_ready (cor_rdy[i+1]),
            .o_rot   (cor_rot[i+1])
        );
    end

    assign cor_rdy[CORDIC_STAGES] = pose_rdy;

    fkc_pose #(
        .DW (DATA_WIDTH)
    ) u_pose (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cor_v[CORDIC_STAGES]),
        .o_ready (pose_rdy),
        .i_rot   (cor_rot[CORDIC_STAGES]),
        .i_len   (r_len),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (pose_data)
    );

    assign o_m_axis_tdata = OUT_W'(pose_data);

endmodule

FILE: sv/fkc_checker.sv
// Port-level checks of the kinematics pipeline, bound to the top level.
module fkc_checker #(
    parameter int DATA_WIDTH = 18
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [((12*DATA_WIDTH+7)/8)*8-1:0]  o_m_axis_tdata
);

    // An empty or draining output stage frees the whole pipeline
    a_ready_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input not ready while output side drains");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed or dropped");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind arm_end_pose_forward_kinematics fkc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_fkc_checker (.*);
